FILE: design/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// shared types for the huffman code builder: controller commands and status
// ----------------------------------------------------------------------------
package hcb_pkg;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_LOAD  = 3'd1,
      OP_CLEAR = 3'd2,
      OP_SCAN  = 3'd3,
      OP_MERGE = 3'd4,
      OP_WALK  = 3'd5,
      OP_EMIT  = 3'd6
   } op_type;

   typedef struct packed {
      op_type op;
      logic   scan_first;
      logic   walk_first;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic build_done;
      logic walk_done;
      logic emit_done;
   } status_type;

endpackage

FILE: design/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl
// sequencer: load, clear, merge scans, code walks and emission
// ----------------------------------------------------------------------------
module hcb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_last,
   input  hcb_pkg::status_type sts,
   output hcb_pkg::cmd_type    cmd,
   output logic               busy
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_MERGE = 6'b001000,
      ST_WALK  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      first_ff, first_in;

   always_comb begin
      state_in = state_ff;
      first_in = 1'b0;
      cmd.op = hcb_pkg::OP_NONE;
      cmd.scan_first = first_ff;
      cmd.walk_first = first_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op = hcb_pkg::OP_LOAD;
               if (req_last) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            cmd.op = hcb_pkg::OP_CLEAR;
            first_in = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.build_done) begin
               state_in = ST_WALK;
               first_in = 1'b1;
            end else begin
               cmd.op = hcb_pkg::OP_SCAN;
               if (sts.scan_done) begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            cmd.op = hcb_pkg::OP_MERGE;
            first_in = 1'b1;
            state_in = ST_SCAN;
         end
         ST_WALK: begin
            if (sts.emit_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.op = hcb_pkg::OP_WALK;
               if (sts.walk_done) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            cmd.op = hcb_pkg::OP_EMIT;
            first_in = 1'b1;
            state_in = ST_WALK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   a_merge_to_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |=> state_ff == ST_SCAN)
      else $error("merge not followed by scan");
   a_emit_to_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |=> state_ff == ST_WALK)
      else $error("emit not followed by walk");
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && req_last) |=> state_ff == ST_CLEAR)
      else $error("last word did not start build");

endmodule

FILE: design/hcb_datapath.sv
// ----------------------------------------------------------------------------
// hcb_datapath
// node stores, the merge scanner and the leaf-to-root code walker
// ----------------------------------------------------------------------------
module hcb_datapath #(
   parameter int MAX_SYMBOLS = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  hcb_pkg::cmd_type    cmd,
   input  logic [7:0]         req_symbol,
   input  logic [15:0]        req_weight,
   output hcb_pkg::status_type sts,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_symbol,
   output logic [14:0]        rsp_code_bits,
   output logic [3:0]         rsp_code_length,
   output logic               rsp_last_code
);

   localparam int NODES = 2 * MAX_SYMBOLS - 1;
   localparam int IW    = $clog2(NODES + 1);
   localparam int SW    = $clog2(MAX_SYMBOLS + 1);
   localparam int SIW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int NW    = WEIGHT_BITS + SIW + 1;
   localparam int LW    = $clog2(NODES + 1);
   // weight bits taken from the 16-bit port
   localparam int WIN   = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

   logic [7:0]       sym_mem [MAX_SYMBOLS];
   logic [NW-1:0]    wgt_mem [NODES];
   logic [IW-1:0]    par_mem [NODES];
   logic [IW-1:0]    lft_mem [NODES];
   logic [NODES-1:0] merged_ff;

   logic [SW-1:0]  count_ff;
   logic [IW-1:0]  next_ff;     // index of the node being created
   logic [IW-1:0]  j_ff;
   logic           have1_ff, have2_ff;
   logic [NW-1:0]  w1_ff, w2_ff;
   logic [IW-1:0]  p1_ff, p2_ff;
   logic [SW-1:0]  k_ff;        // leaf being walked
   logic [IW-1:0]  node_ff;
   logic [14:0]    code_ff;
   logic [LW-1:0]  len_ff;

   logic [IW-1:0]  j_cur;
   logic           h1, h2;
   logic [NW-1:0]  w1, w2, wj;
   logic [IW-1:0]  p1, p2;
   logic           j_ok;
   logic [IW-1:0]  up;

   always_comb begin
      j_cur = cmd.scan_first ? '0 : j_ff;
      h1 = cmd.scan_first ? 1'b0 : have1_ff;
      h2 = cmd.scan_first ? 1'b0 : have2_ff;
      w1 = w1_ff;
      w2 = w2_ff;
      p1 = p1_ff;
      p2 = p2_ff;
      j_ok = (j_cur < next_ff) && (j_cur < IW'(NODES));
      wj = wgt_mem[j_cur[IW-1:0] < IW'(NODES) ? j_cur : '0];
      if (j_ok && !merged_ff[j_cur < IW'(NODES) ? j_cur : '0]) begin
         if (!h1 || wj < w1) begin
            w2 = w1; p2 = p1; h2 = h1;
            w1 = wj; p1 = j_cur; h1 = 1'b1;
         end else if (!h2 || wj < w2) begin
            w2 = wj; p2 = j_cur; h2 = 1'b1;
         end
      end
   end

   assign sts.scan_done  = (j_cur + IW'(1) >= next_ff);
   assign sts.build_done = ({1'b0, next_ff} + 1'b1 >= {count_ff, 1'b0})
                           || (next_ff >= IW'(NODES));
   assign sts.emit_done  = (k_ff >= count_ff);

   logic [IW-1:0] node_cur;
   logic [14:0]   code_cur;
   logic [LW-1:0] len_cur;
   logic          up_step;
   always_comb begin
      node_cur = cmd.walk_first ? IW'(k_ff) : node_ff;
      code_cur = cmd.walk_first ? '0 : code_ff;
      len_cur  = cmd.walk_first ? '0 : len_ff;
      up_step  = (node_cur < IW'(NODES)) && merged_ff[node_cur < IW'(NODES) ? node_cur : '0];
      up       = par_mem[node_cur < IW'(NODES) ? node_cur : '0];
   end
   assign sts.walk_done = !up_step;

   always_ff @(posedge clock) begin
      if (cmd.op == hcb_pkg::OP_LOAD && count_ff < SW'(MAX_SYMBOLS)) begin
         sym_mem[count_ff[SIW-1:0]] <= req_symbol;
         wgt_mem[count_ff[SIW-1:0]] <= NW'(req_weight[WIN-1:0]);
      end
      if (cmd.op == hcb_pkg::OP_MERGE) begin
         par_mem[p1_ff] <= next_ff;
         par_mem[p2_ff] <= next_ff;
         lft_mem[next_ff] <= p1_ff;
         wgt_mem[next_ff] <= w1_ff + w2_ff;
      end
      if (cmd.op == hcb_pkg::OP_SCAN) begin
         j_ff <= j_cur + IW'(1);
         have1_ff <= h1; have2_ff <= h2;
         w1_ff <= w1; w2_ff <= w2;
         p1_ff <= p1; p2_ff <= p2;
      end
      if (cmd.op == hcb_pkg::OP_WALK && up_step) begin
         // walk builds code lsb-first, leaf bit lowest
         if (lft_mem[up] != node_cur && len_cur < LW'(15)) begin
            code_ff <= code_cur | (15'd1 << len_cur[3:0]);
         end else begin
            code_ff <= code_cur;
         end
         len_ff  <= len_cur + LW'(1);
         node_ff <= up;
      end else if (cmd.op == hcb_pkg::OP_WALK) begin
         code_ff <= code_cur;
         len_ff  <= len_cur;
         node_ff <= node_cur;
      end
      rsp_out_symbol  <= sym_mem[k_ff[SIW-1:0]];
      rsp_code_bits   <= code_ff;
      rsp_code_length <= len_ff[3:0];
      rsp_last_code   <= (k_ff + SW'(1) == count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         merged_ff <= '0;
         next_ff   <= '0;
         k_ff      <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (cmd.op == hcb_pkg::OP_EMIT);
         case (cmd.op)
            hcb_pkg::OP_LOAD: begin
               if (count_ff < SW'(MAX_SYMBOLS)) begin
                  count_ff <= count_ff + SW'(1);
               end
            end
            hcb_pkg::OP_CLEAR: begin
               merged_ff <= '0;
               next_ff   <= IW'(count_ff);
               k_ff      <= '0;
            end
            hcb_pkg::OP_MERGE: begin
               merged_ff[p1_ff] <= 1'b1;
               merged_ff[p2_ff] <= 1'b1;
               next_ff <= next_ff + IW'(1);
            end
            hcb_pkg::OP_EMIT: begin
               k_ff <= k_ff + SW'(1);
               if (k_ff + SW'(1) == count_ff) begin
                  count_ff <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   a_merge_distinct: assert property (@(posedge clock) disable iff (reset)
      cmd.op == hcb_pkg::OP_MERGE |-> p1_ff != p2_ff)
      else $error("merge picked one node twice");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SW'(MAX_SYMBOLS))
      else $error("symbol count overflow");
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == hcb_pkg::OP_EMIT |-> k_ff < count_ff)
      else $error("emit past loaded symbols");

endmodule

FILE: design/huffman_code_builder_core.sv
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// collects weighted symbols and emits a huffman code per symbol, ties to the lower node
//
// channel  direction  handshake
// req_     in         start high while busy low
// rsp_     out        rsp_valid strobe, one cycle per word
//
// symbols load one per cycle while idle. a word with req_last starts the build:
// a clear step, then for each merge creating node m a scan over nodes 0..m-1
// (one node per cycle) plus a merge step, and a step that sees the build is
// done; then per symbol a leaf-to-root walk plus an emit step, and a closing
// step before idle.
// busy stays high from the last word until the final code is out.
// reset clears the symbol count and sequencer; the receiver cannot stall.
// ----------------------------------------------------------------------------
module huffman_code_builder_core #(
   parameter int MAX_SYMBOLS = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_symbol,
   input  logic [15:0] req_weight,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_symbol,
   output logic [14:0] rsp_code_bits,
   output logic [3:0]  rsp_code_length,
   output logic        rsp_last_code
);

   hcb_pkg::cmd_type    cmd;
   hcb_pkg::status_type sts;

   hcb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_last(req_last),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   hcb_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_symbol(req_symbol), .req_weight(req_weight), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_out_symbol(rsp_out_symbol),
      .rsp_code_bits(rsp_code_bits), .rsp_code_length(rsp_code_length),
      .rsp_last_code(rsp_last_code)
   );

endmodule
